// ===== rtl/assert_macros.svh =====
// Assertion helpers included by the dedup table unit.
// Every check is sampled on the rising edge of clk and is off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/irdt_pkg.sv =====
package irdt_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 32;
  localparam int SLOT_LIMIT  = (TABLE_DEPTH < 32) ? TABLE_DEPTH : 32;
  localparam int SLOT_IDX_W  = $clog2(SLOT_LIMIT);
  localparam int SLOT_W      = 5;
  localparam int ORDER_DEPTH = 32;
  localparam int ORDER_IDX_W = 5;
  localparam int COUNT_W     = 6;

  localparam logic [COUNT_W-1:0] ORDER_FULL   = COUNT_W'(ORDER_DEPTH);
  localparam logic [COUNT_W-1:0] SLOT_LIMIT_C = COUNT_W'(SLOT_LIMIT);

  // Configuration register indexes and reset values.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_SECS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HANG_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_CAP  = 2'd2;

  localparam logic [15:0] KEEP_SECS_RST  = 16'd5;
  localparam logic [15:0] HANG_LIMIT_RST = 16'd30;
  localparam logic [4:0]  ENTRY_CAP_RST  = 5'd31;

  // Request kinds.
  localparam logic KIND_NEW  = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // Verdict codes.
  localparam logic [1:0] VERDICT_ACCEPT = 2'd0;
  localparam logic [1:0] VERDICT_DUP    = 2'd1;
  localparam logic [1:0] VERDICT_DROP   = 2'd2;
  localparam logic [1:0] VERDICT_KILL   = 2'd3;

  typedef struct packed {
    logic              kind;
    logic [31:0]       now_seconds;
    logic [31:0]       client_addr;
    logic [15:0]       client_port;
    logic [7:0]        request_id;
    logic [SLOT_W-1:0] done_slot;
  } req_t;

  typedef struct packed {
    logic [1:0]        verdict;
    logic [SLOT_W-1:0] slot;
    logic              last;
  } rsp_t;

  // One table entry as stored in the entry memory.
  typedef struct packed {
    logic        pending;
    logic [31:0] stamp;
    logic [31:0] addr;
    logic [15:0] port;
    logic [7:0]  ident;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

endpackage

// ===== rtl/irdt_ram.sv =====
module irdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/inflight_request_dedup_table_unit.sv =====
// Sequence: a new request walks the order list through the order stage and the evaluate
// stage, then decides; a duplicate adds a compaction sweep of the rest of the list.
// A completion reads the entry, then writes it, keeps busy high and gives no result.
// Throughput: one request at a time; the walk reads one entry per cycle through the
// order memory and the entry memory.
// Reset (rst_n low at a clock edge) empties the table and restores register defaults.
module inflight_request_dedup_table_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  irdt_pkg::req_t                      in_data,
  output logic                                out_valid,
  output irdt_pkg::rsp_t                      out_data,
  input  logic                                cfg_we,
  input  logic [irdt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [irdt_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  `include "assert_macros.svh"

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_CMPL_RD = 3'd1;
  localparam logic [2:0] ST_CMPL_WR = 3'd2;
  localparam logic [2:0] ST_WALK    = 3'd3;
  localparam logic [2:0] ST_DECIDE  = 3'd4;
  localparam logic [2:0] ST_COPY    = 3'd5;

  // Control and configuration registers.
  logic [2:0]                              state_r, state_nxt;
  logic [irdt_pkg::SLOT_LIMIT-1:0]         valid_r, valid_nxt;
  logic [irdt_pkg::COUNT_W-1:0]            count_r, count_nxt;
  logic [15:0]                             cleanup_r, cleanup_nxt;
  logic [15:0]                             hang_r, hang_nxt;
  logic [4:0]                              max_r, max_nxt;
  irdt_pkg::req_t                          req_r, req_nxt;

  // Walk pipeline: read pointer, write pointer, order stage and evaluate stage.
  logic [irdt_pkg::COUNT_W-1:0]            rd_r, rd_nxt;
  logic [irdt_pkg::COUNT_W-1:0]            w_r, w_nxt;
  logic                                    b_vld_r, b_vld_nxt;
  logic [irdt_pkg::ORDER_IDX_W-1:0]        b_idx_r, b_idx_nxt;
  logic                                    c_vld_r, c_vld_nxt;
  logic [irdt_pkg::SLOT_W-1:0]             c_slot_r, c_slot_nxt;
  logic [irdt_pkg::ORDER_IDX_W-1:0]        c_idx_r, c_idx_nxt;

  logic                                    out_valid_r, out_valid_nxt;
  irdt_pkg::rsp_t                          out_data_r, out_data_nxt;

  // Memory ports.
  logic                                    ord_we;
  logic [irdt_pkg::ORDER_IDX_W-1:0]        ord_waddr;
  logic [irdt_pkg::SLOT_W-1:0]             ord_wdata;
  logic [irdt_pkg::SLOT_W-1:0]             ord_rdata;
  logic                                    rec_we;
  logic [irdt_pkg::SLOT_IDX_W-1:0]         rec_waddr;
  irdt_pkg::rec_t                          rec_wdata;
  logic [irdt_pkg::SLOT_IDX_W-1:0]         rec_raddr;
  logic [irdt_pkg::REC_W-1:0]              rec_rdata;
  irdt_pkg::rec_t                          rec_q;

  // Entry evaluation.
  logic [irdt_pkg::SLOT_IDX_W-1:0]         c_sidx;
  logic [irdt_pkg::SLOT_IDX_W-1:0]         done_sidx;
  logic [31:0]                             clean_sum;
  logic [31:0]                             hang_sum;
  logic                                    ent_live;
  logic                                    expired;
  logic                                    key_hit;
  logic                                    hung;
  logic                                    ev_drop;
  logic                                    dup_hit;
  logic                                    ev_keep;
  logic                                    ev_kill;
  logic                                    done_live;
  logic                                    full;
  logic                                    free_found;
  logic [irdt_pkg::SLOT_IDX_W-1:0]         free_idx;

  irdt_ram #(
    .WIDTH (irdt_pkg::SLOT_W),
    .DEPTH (irdt_pkg::ORDER_DEPTH)
  ) u_order_ram (
    .clk     (clk),
    .wr_en   (ord_we),
    .wr_addr (ord_waddr),
    .wr_data (ord_wdata),
    .rd_addr (rd_r[irdt_pkg::ORDER_IDX_W-1:0]),
    .rd_data (ord_rdata)
  );

  irdt_ram #(
    .WIDTH (irdt_pkg::REC_W),
    .DEPTH (irdt_pkg::SLOT_LIMIT)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (rec_we),
    .wr_addr (rec_waddr),
    .wr_data (rec_wdata),
    .rd_addr (rec_raddr),
    .rd_data (rec_rdata)
  );

  assign rec_q     = irdt_pkg::rec_t'(rec_rdata);
  assign c_sidx    = c_slot_r[irdt_pkg::SLOT_IDX_W-1:0];
  assign done_sidx = req_r.done_slot[irdt_pkg::SLOT_IDX_W-1:0];

  // The entry memory is read at the completion slot, otherwise at the slot
  // that the order memory has just returned.
  assign rec_raddr = (state_r == ST_CMPL_RD) ? done_sidx
                                             : ord_rdata[irdt_pkg::SLOT_IDX_W-1:0];

  // Checks on the entry in the evaluate stage.
  assign clean_sum = rec_q.stamp + {16'd0, cleanup_r};
  assign hang_sum  = rec_q.stamp + {16'd0, hang_r};
  assign ent_live  = ({1'b0, c_slot_r} < irdt_pkg::SLOT_LIMIT_C) && valid_r[c_sidx];
  assign expired   = !rec_q.pending && (clean_sum <= req_r.now_seconds);
  assign key_hit   = (rec_q.addr == req_r.client_addr) && (rec_q.port == req_r.client_port)
                     && (rec_q.ident == req_r.request_id);
  assign hung      = rec_q.pending && (hang_sum <= req_r.now_seconds);

  assign ev_drop = (state_r == ST_WALK) && c_vld_r && ent_live && expired;
  assign dup_hit = (state_r == ST_WALK) && c_vld_r && ent_live && !expired && key_hit;
  assign ev_keep = (state_r == ST_WALK) && c_vld_r && ent_live && !expired && !key_hit;
  assign ev_kill = ev_keep && hung;

  assign done_live = ({1'b0, req_r.done_slot} < irdt_pkg::SLOT_LIMIT_C)
                     && valid_r[done_sidx] && rec_q.pending;

  assign full = (w_r > {1'b0, max_r}) || (w_r >= irdt_pkg::ORDER_FULL);

  // Lowest free slot.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = irdt_pkg::SLOT_LIMIT - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = irdt_pkg::SLOT_IDX_W'(i);
      end
    end
  end

  // Sequencer, walk pipeline and memory write ports.
  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    count_nxt     = count_r;
    cleanup_nxt   = cleanup_r;
    hang_nxt      = hang_r;
    max_nxt       = max_r;
    req_nxt       = req_r;
    rd_nxt        = rd_r;
    w_nxt         = w_r;
    b_vld_nxt     = 1'b0;
    b_idx_nxt     = b_idx_r;
    c_vld_nxt     = 1'b0;
    c_slot_nxt    = c_slot_r;
    c_idx_nxt     = c_idx_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    ord_we        = 1'b0;
    ord_waddr     = w_r[irdt_pkg::ORDER_IDX_W-1:0];
    ord_wdata     = c_slot_r;
    rec_we        = 1'b0;
    rec_waddr     = c_sidx;
    rec_wdata     = rec_q;

    // Configuration writes must arrive only while the block is idle; the block does not enforce this.
    if (cfg_we) begin
      case (cfg_index)
        irdt_pkg::CFG_KEEP_SECS:  cleanup_nxt = cfg_wdata[15:0];
        irdt_pkg::CFG_HANG_LIMIT: hang_nxt    = cfg_wdata[15:0];
        irdt_pkg::CFG_ENTRY_CAP:  max_nxt     = cfg_wdata[4:0];
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          req_nxt = in_data;
          rd_nxt  = '0;
          w_nxt   = '0;
          state_nxt = (in_data.kind == irdt_pkg::KIND_DONE) ? ST_CMPL_RD : ST_WALK;
        end
      end

      ST_CMPL_RD: begin
        state_nxt = ST_CMPL_WR;
      end

      // Mark a pending entry finished and restamp it.
      ST_CMPL_WR: begin
        if (done_live) begin
          rec_we            = 1'b1;
          rec_waddr         = done_sidx;
          rec_wdata.pending = 1'b0;
          rec_wdata.stamp   = req_r.now_seconds;
        end
        state_nxt = ST_IDLE;
      end

      ST_WALK: begin
        // Issue the next order read unless the walk stops here.
        if ((rd_r < count_r) && !dup_hit) begin
          b_vld_nxt = 1'b1;
          b_idx_nxt = rd_r[irdt_pkg::ORDER_IDX_W-1:0];
          rd_nxt    = rd_r + 1'b1;
        end
        // The order stage hands its slot to the evaluate stage.
        c_vld_nxt  = b_vld_r && !dup_hit;
        c_slot_nxt = ord_rdata;
        c_idx_nxt  = b_idx_r;

        if (ev_drop) begin
          valid_nxt[c_sidx] = 1'b0;
        end
        if (ev_keep) begin
          ord_we = 1'b1;
          w_nxt  = w_r + 1'b1;
        end
        if (ev_kill) begin
          rec_we            = 1'b1;
          rec_wdata.pending = 1'b0;
          out_valid_nxt     = 1'b1;
          out_data_nxt      = '{verdict: irdt_pkg::VERDICT_KILL, slot: c_slot_r, last: 1'b0};
        end
        if (dup_hit) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{verdict: irdt_pkg::VERDICT_DUP, slot: '0, last: 1'b1};
          rd_nxt        = {1'b0, c_idx_r};
          state_nxt     = ST_COPY;
        end else if ((rd_r == count_r) && !b_vld_r && !c_vld_r) begin
          state_nxt = ST_DECIDE;
        end
      end

      // Append the request in the lowest free slot, or drop it.
      ST_DECIDE: begin
        out_valid_nxt = 1'b1;
        count_nxt     = w_r;
        if (full || !free_found) begin
          out_data_nxt = '{verdict: irdt_pkg::VERDICT_DROP, slot: '0, last: 1'b1};
        end else begin
          valid_nxt[free_idx] = 1'b1;
          count_nxt           = w_r + 1'b1;
          ord_we              = 1'b1;
          ord_wdata           = irdt_pkg::SLOT_W'(free_idx);
          rec_we              = 1'b1;
          rec_waddr           = free_idx;
          rec_wdata           = '{pending: 1'b1, stamp: req_r.now_seconds,
                                  addr: req_r.client_addr, port: req_r.client_port,
                                  ident: req_r.request_id};
          out_data_nxt        = '{verdict: irdt_pkg::VERDICT_ACCEPT,
                                  slot: irdt_pkg::SLOT_W'(free_idx), last: 1'b1};
        end
        state_nxt = ST_IDLE;
      end

      // Shift the order list, from the duplicate on, down behind the survivors.
      ST_COPY: begin
        if (rd_r < count_r) begin
          b_vld_nxt = 1'b1;
          rd_nxt    = rd_r + 1'b1;
        end
        if (b_vld_r) begin
          ord_we    = 1'b1;
          ord_wdata = ord_rdata;
          w_nxt     = w_r + 1'b1;
        end
        if ((rd_r == count_r) && !b_vld_r) begin
          count_nxt = w_r;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      count_r     <= '0;
      cleanup_r   <= irdt_pkg::KEEP_SECS_RST;
      hang_r      <= irdt_pkg::HANG_LIMIT_RST;
      max_r       <= irdt_pkg::ENTRY_CAP_RST;
      b_vld_r     <= 1'b0;
      c_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      count_r     <= count_nxt;
      cleanup_r   <= cleanup_nxt;
      hang_r      <= hang_nxt;
      max_r       <= max_nxt;
      b_vld_r     <= b_vld_nxt;
      c_vld_r     <= c_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and pointer registers.
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    rd_r       <= rd_nxt;
    w_r        <= w_nxt;
    b_idx_r    <= b_idx_nxt;
    c_slot_r   <= c_slot_nxt;
    c_idx_r    <= c_idx_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The evaluate stage only carries entries during the walk.
  `ASSERT_IMPLY(a_stage_in_walk, c_vld_r, state_r == ST_WALK, "evaluate stage busy outside walk")
  // Compaction never overtakes the entry being evaluated.
  `ASSERT_IMPLY(a_write_behind, c_vld_r, w_r <= {1'b0, c_idx_r}, "order write ahead of read")
  `ASSERT_ALWAYS(a_count_range, count_r <= irdt_pkg::ORDER_FULL, "entry count out of range")
  `ASSERT_NEXT(a_start_busy, start && !busy, busy, "request taken without going busy")
  // A kill notice is never the final result of a request.
  `ASSERT_IMPLY(a_kill_busy, out_valid && out_data.verdict == irdt_pkg::VERDICT_KILL, busy,
                "kill notice after the request ended")

endmodule
